// ===== src/sbtr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbtr_pkg
// Shared widths, codes and types of the scaled bitmap text renderer.
// ----------------------------------------------------------------------------
package sbtr_pkg;

  localparam int OP_W       = 2;
  localparam int CHAR_W     = 7;
  localparam int GCOORD_W   = 3;
  localparam int COLOR_W    = 32;
  localparam int PIX_X_W    = 10;
  localparam int PIX_Y_W    = 9;
  localparam int SIZE_W     = 5;
  localparam int GDIM_W     = 4;
  localparam int ALPHA_LSB  = 24;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
  localparam logic [SIZE_W-1:0] SCALE_MAX    = SIZE_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ORIGIN = 2'd1,
    OP_DRAW   = 2'd2
  } op_e;

  // Clamped configuration as seen by the sequencer
  typedef struct packed {
    logic [GDIM_W-1:0] glyph_width;
    logic [GDIM_W-1:0] glyph_height;
    logic [SIZE_W-1:0] pixel_scale;
  } cfg_t;

endpackage

// ===== src/sbtr_in_if.sv =====
// ----------------------------------------------------------------------------
// sbtr_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface sbtr_in_if import sbtr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CHAR_W-1:0]   char_code;
  logic [GCOORD_W-1:0] glyph_col;
  logic [GCOORD_W-1:0] glyph_row;
  logic [COLOR_W-1:0]  font_color;
  logic [PIX_X_W-1:0]  text_x;
  logic [PIX_Y_W-1:0]  text_y;

  modport source (
    output valid, op, char_code, glyph_col, glyph_row, font_color, text_x, text_y,
    input  ready
  );
  modport sink (
    input  valid, op, char_code, glyph_col, glyph_row, font_color, text_x, text_y,
    output ready
  );
endinterface

// ===== src/sbtr_out_if.sv =====
// ----------------------------------------------------------------------------
// sbtr_out_if
// Result channel: valid/ready handshake with one square per transfer.
// ----------------------------------------------------------------------------
interface sbtr_out_if import sbtr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_X_W-1:0] pixel_x;
  logic [PIX_Y_W-1:0] pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic [SIZE_W-1:0]  square_size;
  logic               last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, square_size, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, square_size, last,
    output ready
  );
endinterface

// ===== src/sbtr_cfg.sv =====
// ----------------------------------------------------------------------------
// sbtr_cfg
// APB register file for glyph size and pixel scale, with range clamping.
// ----------------------------------------------------------------------------
module sbtr_cfg import sbtr_pkg::*; #(
  parameter int GLYPH_MAX = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  typedef enum logic [1:0] {
    REG_GLYPH_WIDTH  = 2'd0,
    REG_GLYPH_HEIGHT = 2'd1,
    REG_PIXEL_SCALE  = 2'd2
  } reg_e;

  logic [GDIM_W-1:0] width_q;
  logic [GDIM_W-1:0] height_q;
  logic [SIZE_W-1:0] scale_q;
  reg_e              reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GDIM_W'(8);
      height_q <= GDIM_W'(8);
      scale_q  <= SIZE_W'(1);
    end else if (wr_en) begin
      case (reg_sel)
        REG_GLYPH_WIDTH:  width_q  <= pwdata[GDIM_W-1:0];
        REG_GLYPH_HEIGHT: height_q <= pwdata[GDIM_W-1:0];
        REG_PIXEL_SCALE:  scale_q  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GLYPH_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_GLYPH_HEIGHT: prdata = APB_DATA_W'(height_q);
      REG_PIXEL_SCALE:  prdata = APB_DATA_W'(scale_q);
      default:          prdata = '0;
    endcase
  end

  // Zero acts as one, anything above the limit as the limit
  always_comb begin
    if (width_q == '0)                  cfg_o.glyph_width = GDIM_W'(1);
    else if (int'(width_q) > GLYPH_MAX) cfg_o.glyph_width = GDIM_W'(GLYPH_MAX);
    else                                cfg_o.glyph_width = width_q;

    if (height_q == '0)                  cfg_o.glyph_height = GDIM_W'(1);
    else if (int'(height_q) > GLYPH_MAX) cfg_o.glyph_height = GDIM_W'(GLYPH_MAX);
    else                                 cfg_o.glyph_height = height_q;

    if (scale_q == '0)           cfg_o.pixel_scale = SIZE_W'(1);
    else if (scale_q > SCALE_MAX) cfg_o.pixel_scale = SCALE_MAX;
    else                         cfg_o.pixel_scale = scale_q;
  end

endmodule

// ===== src/sbtr_glyph_mem.sv =====
// ----------------------------------------------------------------------------
// sbtr_glyph_mem
// Glyph store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbtr_glyph_mem import sbtr_pkg::*; #(
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [COLOR_W-1:0]       wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [COLOR_W-1:0]       rdata_o
);

  logic [COLOR_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/sbtr_seq.sv =====
// ----------------------------------------------------------------------------
// sbtr_seq
// Sequencer: pen state, glyph scan over the store, modulo step unit and
// result staging.
// ----------------------------------------------------------------------------
module sbtr_seq import sbtr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int GLYPH_MAX     = 8,
  parameter int CHAR_COUNT    = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  sbtr_in_if.sink               in_i,
  sbtr_out_if.source            out_o,
  output logic                  mem_we_o,
  output logic [$clog2(CHAR_COUNT*GLYPH_MAX*GLYPH_MAX)-1:0] mem_waddr_o,
  output logic [COLOR_W-1:0]    mem_wdata_o,
  output logic                  mem_re_o,
  output logic [$clog2(CHAR_COUNT*GLYPH_MAX*GLYPH_MAX)-1:0] mem_raddr_o,
  input  logic [COLOR_W-1:0]    mem_rdata_i
);

  localparam int XW = ($clog2(SCREEN_WIDTH) > PIX_X_W) ? $clog2(SCREEN_WIDTH) : PIX_X_W;
  localparam int YW = ($clog2(SCREEN_HEIGHT) > PIX_Y_W) ? $clog2(SCREEN_HEIGHT) : PIX_Y_W;
  localparam int GLYPH_SIZE = GLYPH_MAX * GLYPH_MAX;
  localparam int AW = $clog2(CHAR_COUNT * GLYPH_SIZE);
  localparam int CW = $clog2(GLYPH_MAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORIGIN,
    S_NEWLINE,
    S_NL_END,
    S_DRAW,
    S_FINISH
  } state_e;

  // Step functions: add a small increment, wrap once at the screen edge
  function automatic logic [XW-1:0] step_x(input logic [XW-1:0] v,
                                           input logic [SIZE_W-1:0] inc);
    logic [XW:0] sum;
    sum = {1'b0, v} + (XW+1)'(inc);
    if (sum >= (XW+1)'(SCREEN_WIDTH)) sum = sum - (XW+1)'(SCREEN_WIDTH);
    return sum[XW-1:0];
  endfunction

  function automatic logic [YW-1:0] step_y(input logic [YW-1:0] v,
                                           input logic [SIZE_W-1:0] inc);
    logic [YW:0] sum;
    sum = {1'b0, v} + (YW+1)'(inc);
    if (sum >= (YW+1)'(SCREEN_HEIGHT)) sum = sum - (YW+1)'(SCREEN_HEIGHT);
    return sum[YW-1:0];
  endfunction

  state_e             state_q;
  logic [XW-1:0]      pen_x_q, org_x_q, cx_q, adv_x_q;
  logic [YW-1:0]      pen_y_q, org_y_q, cy_q;
  logic [CW-1:0]      col_q, row_q;
  logic [AW-1:0]      addr_q, rowbase_q;
  logic               pend_valid_q;
  logic [XW-1:0]      pend_x_q;
  logic [YW-1:0]      pend_y_q;
  logic [COLOR_W-1:0] pend_color_q;
  logic               out_valid_q;
  logic [XW-1:0]      out_x_q;
  logic [YW-1:0]      out_y_q;
  logic [COLOR_W-1:0] out_color_q;
  logic [SIZE_W-1:0]  out_size_q;
  logic               out_last_q;

  logic               in_fire;
  op_e                op;
  logic [CHAR_W-1:0]  ch_mod;
  logic [AW-1:0]      ch_base;
  logic [AW-1:0]      nxt_rowbase;
  logic [AW-1:0]      nxt_addr;
  logic               col_last, row_last;
  logic               alpha_nz, out_free, stall, push;
  logic [SIZE_W-1:0]  scale;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.op);
  assign scale      = cfg_i.pixel_scale;

  always_comb begin
    if (int'(in_i.char_code) >= CHAR_COUNT) ch_mod = in_i.char_code - CHAR_W'(CHAR_COUNT);
    else                                    ch_mod = in_i.char_code;
  end

  assign ch_base     = AW'(ch_mod) * AW'(GLYPH_SIZE);
  assign nxt_rowbase = rowbase_q + AW'(GLYPH_MAX);
  assign col_last    = (GDIM_W'(col_q) == cfg_i.glyph_width - GDIM_W'(1));
  assign row_last    = (GDIM_W'(row_q) == cfg_i.glyph_height - GDIM_W'(1));
  assign nxt_addr    = col_last ? nxt_rowbase : addr_q + AW'(1);
  assign alpha_nz    = |mem_rdata_i[COLOR_W-1:ALPHA_LSB];
  assign out_free    = !out_valid_q || out_o.ready;
  assign stall       = alpha_nz && pend_valid_q && !out_free;
  assign push        = ((state_q == S_DRAW) && alpha_nz && pend_valid_q && out_free) ||
                       ((state_q == S_FINISH) && pend_valid_q && out_free);

  // Font loads write straight through; loads outside the glyph are dropped
  assign mem_we_o    = in_fire && (op == OP_LOAD) &&
                       (int'(in_i.glyph_col) < GLYPH_MAX) && (int'(in_i.glyph_row) < GLYPH_MAX);
  assign mem_waddr_o = ch_base + AW'(in_i.glyph_row) * AW'(GLYPH_MAX) + AW'(in_i.glyph_col);
  assign mem_wdata_o = in_i.font_color;

  // Prefetch the next cell while the current one is evaluated
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = nxt_addr;
    if (in_fire && (op == OP_DRAW) && (in_i.char_code != NEWLINE_CODE)) begin
      mem_re_o    = 1'b1;
      mem_raddr_o = ch_base;
    end else if ((state_q == S_DRAW) && !stall && !(col_last && row_last)) begin
      mem_re_o    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pen_x_q      <= '0;
      pen_y_q      <= '0;
      org_x_q      <= '0;
      org_y_q      <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      adv_x_q      <= '0;
      col_q        <= '0;
      row_q        <= '0;
      addr_q       <= '0;
      rowbase_q    <= '0;
      pend_valid_q <= 1'b0;
      pend_x_q     <= '0;
      pend_y_q     <= '0;
      pend_color_q <= '0;
      out_valid_q  <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_color_q  <= '0;
      out_size_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (push) begin
        out_valid_q <= 1'b1;
        out_x_q     <= pend_x_q;
        out_y_q     <= pend_y_q;
        out_color_q <= pend_color_q;
        out_size_q  <= scale;
        out_last_q  <= (state_q == S_FINISH);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            unique case (op)
              OP_ORIGIN: begin
                org_x_q <= XW'(in_i.text_x);
                org_y_q <= YW'(in_i.text_y);
                state_q <= S_ORIGIN;
              end
              OP_DRAW: begin
                row_q <= '0;
                col_q <= '0;
                if (in_i.char_code == NEWLINE_CODE) begin
                  pen_x_q <= org_x_q;
                  state_q <= S_NEWLINE;
                end else begin
                  cx_q      <= pen_x_q;
                  cy_q      <= pen_y_q;
                  addr_q    <= ch_base;
                  rowbase_q <= ch_base;
                  state_q   <= S_DRAW;
                end
              end
              default: ;
            endcase
          end
        end
        S_ORIGIN: begin
          // Reduce the origin by repeated subtraction
          if (org_x_q >= SCREEN_WIDTH) org_x_q <= org_x_q - XW'(SCREEN_WIDTH);
          if (org_y_q >= SCREEN_HEIGHT) org_y_q <= org_y_q - YW'(SCREEN_HEIGHT);
          if ((org_x_q < SCREEN_WIDTH) && (org_y_q < SCREEN_HEIGHT)) begin
            pen_x_q <= org_x_q;
            pen_y_q <= org_y_q;
            state_q <= S_IDLE;
          end
        end
        S_NEWLINE: begin
          pen_y_q <= step_y(pen_y_q, scale);
          row_q   <= row_q + CW'(1);
          if (row_last) state_q <= S_NL_END;
        end
        S_NL_END: begin
          pen_y_q <= step_y(pen_y_q, SIZE_W'(1));
          state_q <= S_IDLE;
        end
        S_DRAW: begin
          if (!stall) begin
            if (alpha_nz) begin
              pend_valid_q <= 1'b1;
              pend_x_q     <= cx_q;
              pend_y_q     <= cy_q;
              pend_color_q <= mem_rdata_i;
            end
            // First row's end gives pen_x + width * scale
            if (col_last && (row_q == '0)) adv_x_q <= step_x(cx_q, scale);
            if (col_last) begin
              if (row_last) begin
                state_q <= S_FINISH;
              end else begin
                col_q     <= '0;
                row_q     <= row_q + CW'(1);
                cx_q      <= pen_x_q;
                cy_q      <= step_y(cy_q, scale);
                rowbase_q <= nxt_rowbase;
                addr_q    <= nxt_rowbase;
              end
            end else begin
              col_q  <= col_q + CW'(1);
              cx_q   <= step_x(cx_q, scale);
              addr_q <= addr_q + AW'(1);
            end
          end
        end
        S_FINISH: begin
          // Flush the held square as the final one, then advance the pen
          if (!pend_valid_q || out_free) begin
            pend_valid_q <= 1'b0;
            pen_x_q      <= step_x(adv_x_q, SIZE_W'(1));
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_x     = out_x_q[PIX_X_W-1:0];
  assign out_o.pixel_y     = out_y_q[PIX_Y_W-1:0];
  assign out_o.pixel_color = out_color_q;
  assign out_o.square_size = out_size_q;
  assign out_o.last        = out_last_q;

`ifndef ASSERT_OFF
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("square still held while idle");

  a_pen_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pen_x_q < SCREEN_WIDTH) && (pen_y_q < SCREEN_HEIGHT))
    else $error("pen left the screen");

  a_cell_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW) |-> ((cx_q < SCREEN_WIDTH) && (cy_q < SCREEN_HEIGHT)))
    else $error("cell corner left the screen");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || out_o.ready))
    else $error("result overwritten before transfer");
`endif

endmodule

// ===== src/scaled_bitmap_text_renderer.sv =====
// ----------------------------------------------------------------------------
// scaled_bitmap_text_renderer
// Character generator drawing scaled glyph squares from a loadable font.
// ----------------------------------------------------------------------------
// A font load writes the glyph store directly. Setting the text origin reduces
// it by repeated screen-size subtraction; both axes subtract in parallel (at
// most the larger of 1023/SCREEN_WIDTH and 511/SCREEN_HEIGHT subtractions).
// A newline steps the pen down by pixel_scale per glyph row, then by one more.
// Drawing a character scans glyph_width * glyph_height font cells: the scan
// reads one glyph store word per font cell through the store's single read
// port, and stalls only while a square waits on a full output register. Each
// visible cell gives one square, the final one flagged with last. The glyph
// store holds CHAR_COUNT * GLYPH_MAX^2 ARGB words and is undefined until loaded.
module scaled_bitmap_text_renderer import sbtr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int GLYPH_MAX     = 8,
  parameter int CHAR_COUNT    = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  sbtr_in_if.sink               in_i,
  sbtr_out_if.source            out_o
);

  localparam int DEPTH = CHAR_COUNT * GLYPH_MAX * GLYPH_MAX;
  localparam int AW    = $clog2(DEPTH);

  cfg_t               cfg;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [COLOR_W-1:0] mem_rdata;

  sbtr_cfg #(
    .GLYPH_MAX (GLYPH_MAX)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sbtr_glyph_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sbtr_seq #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GLYPH_MAX     (GLYPH_MAX),
    .CHAR_COUNT    (CHAR_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

// ===== tb/sv/sbtr_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// sbtr_tb_pkg
// Register map, screen geometry and small helpers shared by the testbench.
// ----------------------------------------------------------------------------
package sbtr_tb_pkg;
  import sbtr_pkg::*;

  localparam int SCREEN_W   = 640;
  localparam int SCREEN_H   = 480;
  localparam int GLYPH_MAX  = 8;
  localparam int CHAR_COUNT = 128;

  // op code that the block drops without effect
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef enum logic [APB_ADDR_W-1:0] {
    REG_GLYPH_WIDTH  = 4'h0,
    REG_GLYPH_HEIGHT = 4'h4,
    REG_PIXEL_SCALE  = 4'h8
  } reg_addr_e;

  // zero acts as one, anything above the limit acts as the limit
  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned glyph_cell(int unsigned ch, int unsigned row,
                                             int unsigned col);
    return (ch * GLYPH_MAX + row) * GLYPH_MAX + col;
  endfunction

endpackage

// ===== tb/sv/sbtr_checker.sv =====
// ----------------------------------------------------------------------------
// sbtr_checker
// Watches the register port and both item channels, keeps a shadow of the
// font, pen and glyph settings, and compares every square against the
// predicted stream in order.
// ----------------------------------------------------------------------------
module sbtr_checker import sbtr_pkg::*, sbtr_tb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  sbtr_in_if                    in_i,
  sbtr_out_if                   out_i,
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_X_W-1:0] x;
    logic [PIX_Y_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic [SIZE_W-1:0]  side;
    logic               last;
  } square_t;

  square_t            square_q[$];
  logic [COLOR_W-1:0] font_mem [CHAR_COUNT*GLYPH_MAX*GLYPH_MAX];
  logic [GDIM_W-1:0]  width_reg, height_reg;
  logic [SIZE_W-1:0]  scale_reg;
  logic [PIX_X_W-1:0] pen_x, origin_x;
  logic [PIX_Y_W-1:0] pen_y, origin_y;

  task automatic note_error(string msg);
    errors_o++;
    if (errors_o <= 10) $display("%0t sbtr_checker: %s", $time, msg);
  endtask

  task automatic render_glyph(int unsigned ch);
    int unsigned w, h, s, n;
    logic [COLOR_W-1:0] c;
    square_t sq;
    w = clamp_dim(width_reg, GLYPH_MAX);
    h = clamp_dim(height_reg, GLYPH_MAX);
    s = clamp_dim(scale_reg, SCALE_MAX);
    n = 0;
    if (ch == NEWLINE_CODE) begin
      pen_x = origin_x;
      pen_y = PIX_Y_W'((pen_y + h * s + 1) % SCREEN_H);
      return;
    end
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned k = 0; k < w; k++) begin
        c = font_mem[glyph_cell(ch, r, k)];
        if (c[COLOR_W-1:ALPHA_LSB] != '0) begin
          sq.x     = PIX_X_W'((pen_x + k * s) % SCREEN_W);
          sq.y     = PIX_Y_W'((pen_y + r * s) % SCREEN_H);
          sq.color = c;
          sq.side  = SIZE_W'(s);
          sq.last  = 1'b0;
          square_q.push_back(sq);
          n++;
        end
      end
    end
    if (n > 0) square_q[square_q.size()-1].last = 1'b1;
    // pen moves on even when the glyph is fully transparent
    pen_x = PIX_X_W'((pen_x + w * s + 1) % SCREEN_W);
  endtask

  task automatic check_square();
    square_t got, want;
    got = '{x: out_i.pixel_x, y: out_i.pixel_y, color: out_i.pixel_color,
            side: out_i.square_size, last: out_i.last};
    if (square_q.size() == 0) begin
      note_error($sformatf("unexpected square x=%0d y=%0d color=%08h side=%0d last=%0b",
                           got.x, got.y, got.color, got.side, got.last));
      return;
    end
    want = square_q.pop_front();
    if (got !== want)
      note_error($sformatf({"square mismatch: expected x=%0d y=%0d color=%08h side=%0d ",
                            "last=%0b, got x=%0d y=%0d color=%08h side=%0d last=%0b"},
                           want.x, want.y, want.color, want.side, want.last,
                           got.x, got.y, got.color, got.side, got.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q.delete();
      width_reg  = 4'd8;
      height_reg = 4'd8;
      scale_reg  = 5'd1;
      pen_x      = '0;
      pen_y      = '0;
      origin_x   = '0;
      origin_y   = '0;
      pending_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_GLYPH_WIDTH:  width_reg  = pwdata[GDIM_W-1:0];
          REG_GLYPH_HEIGHT: height_reg = pwdata[GDIM_W-1:0];
          REG_PIXEL_SCALE:  scale_reg  = pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        case (in_i.op)
          OP_LOAD: font_mem[glyph_cell(in_i.char_code, in_i.glyph_row, in_i.glyph_col)] =
                     in_i.font_color;
          OP_ORIGIN: begin
            origin_x = PIX_X_W'(in_i.text_x % SCREEN_W);
            origin_y = PIX_Y_W'(in_i.text_y % SCREEN_H);
            pen_x    = origin_x;
            pen_y    = origin_y;
          end
          OP_DRAW: render_glyph(in_i.char_code);
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) check_square();
      pending_o = square_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives font loads, origin moves and character draws through several glyph
// settings with random gaps on both channels; the checker scores the squares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbtr_pkg::*;
  import sbtr_tb_pkg::*;

  // longest quiet stretch of the block after its last square
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   char_code;
    logic [GCOORD_W-1:0] glyph_col;
    logic [GCOORD_W-1:0] glyph_row;
    logic [COLOR_W-1:0]  font_color;
    logic [PIX_X_W-1:0]  text_x;
    logic [PIX_Y_W-1:0]  text_y;
  } font_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    chk_errors, chk_pending;

  sbtr_in_if  in_ch();
  sbtr_out_if out_ch();

  bit          cell_done [CHAR_COUNT*GLYPH_MAX*GLYPH_MAX];
  bit          char_used [CHAR_COUNT];
  int unsigned used_chars[$];
  int unsigned cur_w = 8, cur_h = 8;
  int unsigned phase_sent;
  int unsigned src_calm;

  scaled_bitmap_text_renderer #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H),
    .GLYPH_MAX    (GLYPH_MAX),
    .CHAR_COUNT   (CHAR_COUNT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sbtr_checker chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .in_i     (in_ch),
    .out_i    (out_ch),
    .errors_o (chk_errors),
    .pending_o(chk_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly random waits, with runs of back-to-back transfers now and then
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [COLOR_W-1:0] random_font_color();
    logic [COLOR_W-1:0] c;
    c = $urandom;
    if ($urandom_range(0, 3) == 0) c[COLOR_W-1:ALPHA_LSB] = '0;
    return c;
  endfunction

  function automatic font_item_t random_item(logic [OP_W-1:0] op);
    font_item_t it;
    it.op         = op;
    it.char_code  = CHAR_W'($urandom_range(0, CHAR_COUNT - 1));
    it.glyph_col  = GCOORD_W'($urandom_range(0, GLYPH_MAX - 1));
    it.glyph_row  = GCOORD_W'($urandom_range(0, GLYPH_MAX - 1));
    it.font_color = random_font_color();
    it.text_x     = PIX_X_W'($urandom_range(0, 1023));
    it.text_y     = PIX_Y_W'($urandom_range(0, 511));
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic push_item(font_item_t it);
    int unsigned gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.op         <= it.op;
    in_ch.char_code  <= it.char_code;
    in_ch.glyph_col  <= it.glyph_col;
    in_ch.glyph_row  <= it.glyph_row;
    in_ch.font_color <= it.font_color;
    in_ch.text_x     <= it.text_x;
    in_ch.text_y     <= it.text_y;
    in_ch.valid      <= 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    @(negedge clk_i);
    if (it.op == OP_LOAD) cell_done[glyph_cell(it.char_code, it.glyph_row, it.glyph_col)] = 1'b1;
    if (it.op != OP_NONE) phase_sent++;
  endtask

  task automatic send_load(int unsigned ch, int unsigned row, int unsigned col,
                           logic [COLOR_W-1:0] color);
    font_item_t it;
    it            = random_item(OP_LOAD);
    it.char_code  = CHAR_W'(ch);
    it.glyph_row  = GCOORD_W'(row);
    it.glyph_col  = GCOORD_W'(col);
    it.font_color = color;
    push_item(it);
  endtask

  task automatic send_origin(int unsigned tx, int unsigned ty);
    font_item_t it;
    it        = random_item(OP_ORIGIN);
    it.text_x = PIX_X_W'(tx);
    it.text_y = PIX_Y_W'(ty);
    push_item(it);
  endtask

  task automatic send_draw(int unsigned ch);
    font_item_t it;
    it           = random_item(OP_DRAW);
    it.char_code = CHAR_W'(ch);
    push_item(it);
  endtask

  task automatic apb_write(reg_addr_e addr, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold input until every square is out, then give the block time to go idle
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_glyph_config(int unsigned w, int unsigned h, int unsigned s);
    drain_block();
    apb_write(REG_GLYPH_WIDTH, w);
    apb_write(REG_GLYPH_HEIGHT, h);
    apb_write(REG_PIXEL_SCALE, s);
    cur_w = clamp_dim(w & 32'hF, GLYPH_MAX);
    cur_h = clamp_dim(h & 32'hF, GLYPH_MAX);
  endtask

  function automatic int unsigned pick_char();
    if (used_chars.size() > 0 && $urandom_range(0, 9) < 8)
      return used_chars[$urandom_range(0, used_chars.size() - 1)];
    return $urandom_range(0, CHAR_COUNT - 1);
  endfunction

  // load every cell the current glyph size will read, then draw a few times
  task automatic draw_sequence();
    int unsigned ch;
    ch = pick_char();
    if (ch != NEWLINE_CODE) begin
      for (int unsigned r = 0; r < cur_h; r++)
        for (int unsigned k = 0; k < cur_w; k++)
          if (!cell_done[glyph_cell(ch, r, k)]) send_load(ch, r, k, random_font_color());
      if (!char_used[ch]) begin
        char_used[ch] = 1'b1;
        used_chars.push_back(ch);
      end
    end
    repeat ($urandom_range(1, 3)) send_draw(ch);
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned s,
                           int unsigned budget);
    int unsigned roll;
    set_glyph_config(w, h, s);
    phase_sent = 0;
    while (phase_sent < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) draw_sequence();
      else if (roll < 65) send_draw(NEWLINE_CODE);
      else if (roll < 75) push_item(random_item(OP_ORIGIN));
      else if (roll < 90) push_item(random_item(OP_LOAD));
      else push_item(random_item(OP_NONE));
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned sink_calm;
    out_ch.ready = 1'b0;
    sink_calm = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = pick_gap(sink_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    font_item_t junk;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_LOAD;
    in_ch.char_code  = '0;
    in_ch.glyph_col  = '0;
    in_ch.glyph_row  = '0;
    in_ch.font_color = '0;
    in_ch.text_x     = '0;
    in_ch.text_y     = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    src_calm         = 0;
    rst_ni           = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset glyph size: unused op, origin past the screen edge, newline wrap
    junk = '1;
    push_item(junk);
    send_origin(1023, 511);
    send_draw(NEWLINE_CODE);
    send_origin(SCREEN_W - 1, SCREEN_H - 1);
    send_draw(NEWLINE_CODE);

    // tiny glyphs at the largest scale, one transparent cell in char 0
    set_glyph_config(2, 2, 16);
    send_load(0, 0, 0, 32'hFFFF_FFFF);
    send_load(0, 0, 1, 32'h00FF_FFFF);
    send_load(0, 1, 0, 32'h0100_0000);
    send_load(0, 1, 1, 32'h8012_3456);
    send_load(CHAR_COUNT - 1, 0, 0, 32'hFF00_0000);
    send_load(CHAR_COUNT - 1, 0, 1, 32'h7FFF_FFFF);
    send_load(CHAR_COUNT - 1, 1, 0, 32'h40A0_B0C0);
    send_load(CHAR_COUNT - 1, 1, 1, 32'hFFFF_FFFF);
    send_load(CHAR_COUNT - 1, GLYPH_MAX - 1, GLYPH_MAX - 1, 32'hA5A5_5A5A);
    send_origin(0, 0);
    send_draw(0);
    send_draw(CHAR_COUNT - 1);
    send_draw(NEWLINE_CODE);
    // squares wrap on both axes from the bottom-right corner
    send_origin(SCREEN_W - 1, SCREEN_H - 1);
    send_draw(CHAR_COUNT - 1);
    send_draw(0);
    char_used[0] = 1'b1;
    char_used[CHAR_COUNT - 1] = 1'b1;
    used_chars.push_back(0);
    used_chars.push_back(CHAR_COUNT - 1);

    run_phase(3, 2, 16, 25);
    run_phase(8, 8, 1, 60);
    run_phase(0, 15, 0, 20);
    run_phase(15, 1, 31, 25);
    run_phase(5, 7, 3, 20);
    run_phase(4, 4, 2, 20);

    drain_block();
    if (chk_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/sbtr_pkg.sv
src/sbtr_in_if.sv
src/sbtr_out_if.sv
src/sbtr_cfg.sv
src/sbtr_glyph_mem.sv
src/sbtr_seq.sv
src/scaled_bitmap_text_renderer.sv
tb/sv/sbtr_tb_pkg.sv
tb/sv/sbtr_checker.sv
tb/sv/tb_top.sv
